[rtl/rasched_pkg.sv]
// Shared types and constants for the room assignment scheduler.
package rasched_pkg;

    // Field widths of the request and result streams and the config port
    localparam int TIME_IN_W  = 32;
    localparam int TIME_W     = 40;
    localparam int ROOM_W     = 4;
    localparam int RC_W       = 5;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 56;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TIME_W-1:0]     TIME_MAX         = {TIME_W{1'b1}};
    localparam logic [RC_W-1:0]       ROOM_COUNT_RESET = 5'd16;
    localparam logic [APB_ADDR_W-1:0] ADDR_ROOM_COUNT  = 3'd0;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TALLY,
        ST_EMIT
    } sched_state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic upd_en;   // write finish time and bump count of the picked room
        logic clear;    // wipe all room state (end of batch)
    } upd_t;

    // Control part of the token that walks down the chain
    typedef struct packed {
        logic valid;
        logic found;    // a room free at start time has been seen
    } tok_ctl_t;

endpackage

[rtl/rasched_cell.sv]
// One room of the chain: holds its free time and booking count and folds them into the token.
module rasched_cell #(
    parameter int IDX_W      = 4,
    parameter int COUNT_BITS = 32,
    parameter int CELL_IDX   = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              active,
    input  logic [rasched_pkg::TIME_IN_W-1:0] start,
    input  rasched_pkg::upd_t                 upd,
    input  logic [IDX_W-1:0]                  upd_room,
    input  logic [rasched_pkg::TIME_W-1:0]    upd_finish,
    input  rasched_pkg::tok_ctl_t             tok_in_ctl,
    input  logic [IDX_W-1:0]                  tok_in_pick,
    input  logic [rasched_pkg::TIME_W-1:0]    tok_in_min,
    input  logic [IDX_W-1:0]                  tok_in_best,
    input  logic [COUNT_BITS-1:0]             tok_in_bcnt,
    output rasched_pkg::tok_ctl_t             tok_out_ctl,
    output logic [IDX_W-1:0]                  tok_out_pick,
    output logic [rasched_pkg::TIME_W-1:0]    tok_out_min,
    output logic [IDX_W-1:0]                  tok_out_best,
    output logic [COUNT_BITS-1:0]             tok_out_bcnt
);
    import rasched_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [TIME_W-1:0]     free_reg, free_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    tok_ctl_t              ctl_reg, ctl_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [TIME_W-1:0]     min_reg, min_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [COUNT_BITS-1:0] bcnt_reg, bcnt_next;
    logic                  is_free;

    assign is_free = free_reg <= TIME_W'(start);

    // Room state update
    always_comb begin
        free_next = free_reg;
        cnt_next  = cnt_reg;
        if (upd.clear) begin
            free_next = '0;
            cnt_next  = '0;
        end else if (upd.upd_en && upd_room == MY_IDX) begin
            free_next = upd_finish;
            if (cnt_reg != {COUNT_BITS{1'b1}}) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Token fold: first free room wins, else earliest free; busiest by strict compare
    always_comb begin
        ctl_next  = tok_in_ctl;
        pick_next = tok_in_pick;
        min_next  = tok_in_min;
        best_next = tok_in_best;
        bcnt_next = tok_in_bcnt;
        if (active) begin
            if (!tok_in_ctl.found) begin
                if (is_free) begin
                    ctl_next.found = 1'b1;
                    pick_next      = MY_IDX;
                end else if (free_reg < tok_in_min) begin
                    min_next  = free_reg;
                    pick_next = MY_IDX;
                end
            end
            if (cnt_reg > tok_in_bcnt) begin
                best_next = MY_IDX;
                bcnt_next = cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg      <= '0;
            cnt_reg       <= '0;
            ctl_reg.valid <= 1'b0;
            ctl_reg.found <= 1'b0;
        end else begin
            free_reg <= free_next;
            cnt_reg  <= cnt_next;
            ctl_reg  <= ctl_next;
        end
    end

    // Token payload
    always_ff @(posedge aclk) begin
        pick_reg <= pick_next;
        min_reg  <= min_next;
        best_reg <= best_next;
        bcnt_reg <= bcnt_next;
    end

    assign tok_out_ctl  = ctl_reg;
    assign tok_out_pick = pick_reg;
    assign tok_out_min  = min_reg;
    assign tok_out_best = best_reg;
    assign tok_out_bcnt = bcnt_reg;

endmodule

[rtl/room_assignment_scheduler.sv]
// Top level: request control, room cell chain, result register and config port.
// A request launches a token that walks the room chain one cell per cycle; a last request
// sends it down the chain twice, the second time to tally the busiest room. No new request
// is taken until the result of the one before is staged in the result register.
// Reset (aresetn low, synchronous) clears all room state, sets room_count to 16,
// and empties the result register.
module room_assignment_scheduler #(
    parameter int NUM_ROOMS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request: book_start[31:0], end_time[63:32]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rasched_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                               s_tlast,
    // result: room[3:0], finish_time[43:4], busiest_valid[44], busiest_room[48:45], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rasched_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rasched_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rasched_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rasched_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import rasched_pkg::*;

    localparam int IDX_W = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;

    sched_state_t          state_reg, state_next;
    logic [RC_W-1:0]       room_count_reg;
    logic [TIME_IN_W-1:0]  start_reg;
    logic [TIME_IN_W-1:0]  dur_reg;
    logic                  last_reg;
    logic                  launch_reg, launch_next;
    logic [ROOM_W-1:0]     res_room_reg;
    logic [TIME_W-1:0]     res_finish_reg;
    logic                  res_bvalid_reg;
    logic [ROOM_W-1:0]     res_broom_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg;

    logic [TIME_IN_W-1:0]  in_start, in_end;
    logic                  in_accept;
    logic [7:0]            rc_ext, rooms_used;
    logic [NUM_ROOMS-1:0]  room_active;
    logic                  scan_done, tally_done, emit_go;
    logic [TIME_W:0]       finish_sum;
    logic [TIME_W-1:0]     finish_val;
    upd_t                  upd;

    // Token chain, stage 0 fed by the controller
    tok_ctl_t              tok_ctl  [NUM_ROOMS+1];
    logic [IDX_W-1:0]      tok_pick [NUM_ROOMS+1];
    logic [TIME_W-1:0]     tok_min  [NUM_ROOMS+1];
    logic [IDX_W-1:0]      tok_best [NUM_ROOMS+1];
    logic [COUNT_BITS-1:0] tok_bcnt [NUM_ROOMS+1];

    assign in_start  = s_tdata[TIME_IN_W-1:0];
    assign in_end    = s_tdata[2*TIME_IN_W-1:TIME_IN_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Rooms in use: zero counts as one, clamp at NUM_ROOMS
    assign rc_ext     = 8'(room_count_reg);
    assign rooms_used = (rc_ext == 8'd0) ? 8'd1 :
                        ((rc_ext > 8'(NUM_ROOMS)) ? 8'(NUM_ROOMS) : rc_ext);

    assign tok_ctl[0].valid = launch_reg;
    assign tok_ctl[0].found = 1'b0;
    assign tok_pick[0]      = '0;
    assign tok_min[0]       = TIME_MAX;
    assign tok_best[0]      = '0;
    assign tok_bcnt[0]      = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_ROOMS; g++) begin : g_cell
            assign room_active[g] = 8'(g) < rooms_used;
            rasched_cell #(
                .IDX_W      (IDX_W),
                .COUNT_BITS (COUNT_BITS),
                .CELL_IDX   (g)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .active      (room_active[g]),
                .start       (start_reg),
                .upd         (upd),
                .upd_room    (tok_pick[NUM_ROOMS]),
                .upd_finish  (finish_val),
                .tok_in_ctl  (tok_ctl[g]),
                .tok_in_pick (tok_pick[g]),
                .tok_in_min  (tok_min[g]),
                .tok_in_best (tok_best[g]),
                .tok_in_bcnt (tok_bcnt[g]),
                .tok_out_ctl (tok_ctl[g+1]),
                .tok_out_pick(tok_pick[g+1]),
                .tok_out_min (tok_min[g+1]),
                .tok_out_best(tok_best[g+1]),
                .tok_out_bcnt(tok_bcnt[g+1])
            );
        end
    endgenerate

    // Finish time from the returning token: free room starts now, else waits
    assign finish_sum = (tok_ctl[NUM_ROOMS].found ? (TIME_W+1)'(start_reg)
                                                  : (TIME_W+1)'(tok_min[NUM_ROOMS]))
                        + (TIME_W+1)'(dur_reg);
    assign finish_val = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];

    assign scan_done  = (state_reg == ST_SCAN)  && tok_ctl[NUM_ROOMS].valid;
    assign tally_done = (state_reg == ST_TALLY) && tok_ctl[NUM_ROOMS].valid;
    assign emit_go    = (state_reg == ST_EMIT)  && (!m_valid_reg || m_tready);

    assign upd.upd_en = scan_done;
    assign upd.clear  = tally_done;

    // Next state and token launch
    always_comb begin
        state_next   = state_reg;
        launch_next  = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next  = ST_SCAN;
                    launch_next = 1'b1;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (last_reg) begin
                        state_next  = ST_TALLY;
                        launch_next = 1'b1;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_TALLY: begin
                if (tally_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request capture and result staging
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            start_reg <= in_start;
            dur_reg   <= (in_end > in_start) ? (in_end - in_start) : '0;
            last_reg  <= s_tlast;
        end
        if (scan_done) begin
            res_room_reg   <= ROOM_W'(tok_pick[NUM_ROOMS]);
            res_finish_reg <= finish_val;
            res_bvalid_reg <= 1'b0;
            res_broom_reg  <= '0;
        end
        if (tally_done) begin
            res_bvalid_reg <= 1'b1;
            res_broom_reg  <= ROOM_W'(tok_best[NUM_ROOMS]);
        end
        if (emit_go) begin
            m_data_reg <= M_DATA_W'({res_broom_reg, res_bvalid_reg, res_finish_reg,
                                     res_room_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_count_reg <= ROOM_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_ROOM_COUNT) begin
            room_count_reg <= pwdata[RC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ROOM_COUNT) ? APB_DATA_W'(room_count_reg) : '0;

    // Checks
    a_upd_clear_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(upd.upd_en && upd.clear))
        else $error("room update and batch clear in the same cycle");

    a_idle_no_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !launch_reg && !tok_ctl[NUM_ROOMS].valid)
        else $error("request taken while a token is still in the chain");

    a_launch_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |=> !launch_reg)
        else $error("token launched on two consecutive cycles");

    a_emit_after_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_done |=> res_bvalid_reg && state_reg == ST_EMIT)
        else $error("tally result not staged for output");

endmodule
